### rtl/sbfd_pkg.sv
// shared types, mode codes and a helper function for the stop-bit field decoder
// no dependencies; used by sbfd_step, stop_bit_field_decoder, sbfd_checker and testbench
package sbfd_pkg;

    localparam logic [2:0] MODE_UINT32 = 3'd0;
    localparam logic [2:0] MODE_INT32  = 3'd1;
    localparam logic [2:0] MODE_UINT64 = 3'd2;
    localparam logic [2:0] MODE_INT64  = 3'd3;
    localparam logic [2:0] MODE_PMAP   = 3'd4;
    localparam logic [2:0] MODE_ASCII  = 3'd5;

    localparam logic [7:0] STOP_MASK = 8'h80;
    localparam logic [7:0] COUNT_MAX = 8'hFF;

    // per-field decoder state
    typedef struct packed {
        logic [63:0] acc;
        logic [7:0]  seen;
        logic        neg;
        logic [2:0]  mode;
        logic        lost;
    } state_t;

    // one result item
    typedef struct packed {
        logic        overflow;
        logic [7:0]  byte_count;
        logic [6:0]  map_bits;
        logic [63:0] out_value;
        logic        field_last;
    } result_t;

    // bits filled by the data groups of cnt bytes; all ones past nine bytes
    function automatic logic [63:0] fill_mask(input logic [7:0] cnt);
        logic [63:0] m;
        case (cnt)
            8'd0:    m = 64'h0;
            8'd1:    m = 64'h7F;
            8'd2:    m = 64'h3FFF;
            8'd3:    m = 64'h1F_FFFF;
            8'd4:    m = 64'hFFF_FFFF;
            8'd5:    m = 64'h7_FFFF_FFFF;
            8'd6:    m = 64'h3FF_FFFF_FFFF;
            8'd7:    m = 64'h1_FFFF_FFFF_FFFF;
            8'd8:    m = 64'hFF_FFFF_FFFF_FFFF;
            8'd9:    m = 64'h7FFF_FFFF_FFFF_FFFF;
            default: m = '1;
        endcase
        return m;
    endfunction

endpackage

### rtl/sbfd_step.sv
// combinational decode of one stop-bit encoded byte against the field state
// depends on sbfd_pkg
module sbfd_step (
    input  sbfd_pkg::state_t  st,
    input  logic [7:0]        data_byte,
    input  logic [2:0]        mode,
    output sbfd_pkg::state_t  st_next,
    output sbfd_pkg::result_t res,
    output logic              produced
);

    logic        first;
    logic        last;
    logic [6:0]  data;
    logic [2:0]  mode_eff;
    logic        neg_eff;
    logic [7:0]  count;
    logic        is_int;
    logic        wide;
    logic        lost_now;
    logic        lost_eff;
    logic [63:0] shifted;
    logic [63:0] acc_new;
    logic [63:0] ext;
    logic [63:0] value;

    always_comb begin
        first    = (st.seen == 8'd0);
        last     = |(data_byte & sbfd_pkg::STOP_MASK);
        data     = data_byte[6:0];
        mode_eff = first ? mode : st.mode;
        neg_eff  = first ? data_byte[6] : st.neg;
        count    = (st.seen == sbfd_pkg::COUNT_MAX) ? st.seen : st.seen + 8'd1;
        is_int   = (mode_eff == sbfd_pkg::MODE_UINT32) || (mode_eff == sbfd_pkg::MODE_INT32)
                || (mode_eff == sbfd_pkg::MODE_UINT64) || (mode_eff == sbfd_pkg::MODE_INT64);
        wide     = (mode_eff == sbfd_pkg::MODE_UINT64) || (mode_eff == sbfd_pkg::MODE_INT64);

        // top seven bits of the width are about to be shifted out
        lost_now = wide ? |st.acc[63:57] : |st.acc[31:25];
        lost_eff = st.lost | (is_int & lost_now);
        shifted  = {st.acc[56:0], data};
        acc_new  = wide ? shifted : {32'd0, shifted[31:0]};

        // sign fill above the bits received so far
        ext   = acc_new | ~sbfd_pkg::fill_mask(count);
        value = acc_new;
        if ((mode_eff == sbfd_pkg::MODE_INT32) || (mode_eff == sbfd_pkg::MODE_INT64)) begin
            if (neg_eff) begin
                value = wide ? ext : {32'd0, ext[31:0]};
            end
            if (!wide) begin
                value = {{32{value[31]}}, value[31:0]};
            end
        end

        res            = '0;
        res.field_last = last;
        res.byte_count = count;
        produced       = 1'b0;
        if (is_int) begin
            res.out_value = value;
            res.overflow  = lost_eff;
            produced      = last;
        end else if (mode_eff == sbfd_pkg::MODE_PMAP) begin
            res.map_bits = data;
            produced     = 1'b1;
        end else if (mode_eff == sbfd_pkg::MODE_ASCII) begin
            res.out_value = {57'd0, data};
            produced      = 1'b1;
        end

        st_next.mode = mode_eff;
        if (last) begin
            st_next.acc  = '0;
            st_next.seen = '0;
            st_next.neg  = 1'b0;
            st_next.lost = 1'b0;
        end else begin
            st_next.acc  = is_int ? acc_new : st.acc;
            st_next.seen = count;
            st_next.neg  = neg_eff;
            st_next.lost = lost_eff;
        end
    end

endmodule

### rtl/stop_bit_field_decoder.sv
// stop-bit field decoder top level: field state register and result register
// a result is registered and appears on m_tvalid in the cycle after the byte that causes it
// throughput: one byte per cycle while s_tready is high, set by the combinational shift-and-or accumulator
// s_tready stays high while the result register is empty or being taken
// reset (aresetn low, synchronous) clears field state and the result valid
// depends on sbfd_pkg and sbfd_step
module stop_bit_field_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  logic [2:0]  s_tuser,   // mode[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // out_value[63:0], map_bits[70:64], byte_count[78:71],
                                   // overflow[79]
    output logic        m_tlast    // field_last
);

    sbfd_pkg::state_t  state_reg;
    sbfd_pkg::state_t  state_next;
    sbfd_pkg::result_t res_reg;
    sbfd_pkg::result_t res_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic              produced;
    logic              s_xfer;

    sbfd_step u_step (
        .st        (state_reg),
        .data_byte (s_tdata),
        .mode      (s_tuser),
        .st_next   (state_next),
        .res       (res_next),
        .produced  (produced)
    );

    assign s_tready = !m_valid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s_xfer) begin
            m_valid_next = produced;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (s_xfer) begin
                state_reg <= state_next;
            end
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {res_reg.overflow, res_reg.byte_count, res_reg.map_bits, res_reg.out_value};
    assign m_tlast  = res_reg.field_last;

`ifndef SYNTH
    // a stop byte closes the field
    a_stop_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && s_tdata[7]) |=> (state_reg.seen == 8'd0 && !state_reg.lost))
        else $error("field state not cleared after stop byte");

    // a byte that does not stop the field keeps a nonzero count
    a_count_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && !s_tdata[7]) |=> (state_reg.seen != 8'd0))
        else $error("byte count lost inside a field");

    // presence bits come only with a zero value
    a_map_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_reg.map_bits != 7'd0) |-> (res_reg.out_value == 64'd0))
        else $error("presence bits and value both set");

    // overflow needs more than four data groups
    a_ovf_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_reg.overflow) |-> (res_reg.byte_count >= 8'd5))
        else $error("overflow with too few bytes");
`endif

endmodule

### sim/sbfd_checker.sv
// result checker for the stop-bit field decoder: predicts each result from the
// accepted input bytes and compares it with the master-side transfers
// depends on sbfd_pkg for the mode codes and the count limit
module sbfd_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [2:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,
    input  logic        m_tlast,
    output int          mismatches,
    output int          waiting,
    output int          checked
);

    typedef struct packed {
        logic [63:0] value;
        logic [6:0]  map;
        logic        last;
        logic [7:0]  count;
        logic        ovf;
    } decoded_t;

    decoded_t decoded_q[$];

    // field state of the predicted decoder
    logic [63:0] acc;
    logic [7:0]  seen;
    logic        neg;
    logic [2:0]  fmode;
    logic        lost;

    function automatic bit decode_byte(input logic [7:0] b, input logic [2:0] m,
                                       output decoded_t r);
        logic [6:0]  data;
        logic        wide;
        logic [63:0] wmask;
        logic [63:0] value;
        int          width;
        int          count;
        bit          produced;
        data = b[6:0];
        produced = 1'b0;
        if (seen == 8'd0) begin
            fmode = m;
            neg = b[6];
        end
        if (seen != sbfd_pkg::COUNT_MAX)
            seen = seen + 8'd1;
        count = seen;
        r = '0;
        r.last = b[7];
        r.count = seen;
        if (fmode <= sbfd_pkg::MODE_INT64) begin
            wide = (fmode >= sbfd_pkg::MODE_UINT64);
            width = wide ? 64 : 32;
            wmask = wide ? '1 : 64'hFFFF_FFFF;
            if ((acc >> (width - 7)) != 64'd0)
                lost = 1'b1;
            acc = ((acc << 7) | {57'd0, data}) & wmask;
            if (b[7]) begin
                value = acc;
                if (fmode[0]) begin
                    if (neg && count * 7 < width)
                        value = (value | ({64{1'b1}} << (count * 7))) & wmask;
                    if (!wide && value[31])
                        value[63:32] = '1;
                end
                r.value = value;
                r.ovf = lost;
                produced = 1'b1;
            end
        end else if (fmode == sbfd_pkg::MODE_PMAP) begin
            r.map = data;
            produced = 1'b1;
        end else if (fmode == sbfd_pkg::MODE_ASCII) begin
            r.value = {57'd0, data};
            produced = 1'b1;
        end
        if (b[7]) begin
            acc = '0;
            seen = '0;
            neg = 1'b0;
            lost = 1'b0;
        end
        return produced;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected 0x%0h actual 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        decoded_t want;
        decoded_t got;
        if (!aresetn) begin
            acc = '0;
            seen = '0;
            neg = 1'b0;
            fmode = sbfd_pkg::MODE_UINT32;
            lost = 1'b0;
            decoded_q.delete();
        end else begin
            // a result leaves from the result register after its byte is taken, so compare before predicting
            if (m_tvalid && m_tready) begin
                got.value = m_tdata[63:0];
                got.map = m_tdata[70:64];
                got.count = m_tdata[78:71];
                got.ovf = m_tdata[79];
                got.last = m_tlast;
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none actual 0x%0h last %0b",
                             $time, m_tdata, m_tlast);
                    mismatches++;
                end else begin
                    want = decoded_q.pop_front();
                    compare_field("out_value", want.value, got.value);
                    compare_field("map_bits", want.map, got.map);
                    compare_field("field_last", want.last, got.last);
                    compare_field("byte_count", want.count, got.count);
                    compare_field("overflow", want.ovf, got.ovf);
                    checked++;
                end
            end
            if (s_tvalid && s_tready) begin
                if (decode_byte(s_tdata, s_tuser, want))
                    decoded_q.push_back(want);
            end
        end
        waiting = decoded_q.size();
    end

endmodule

### sim/testbench.sv
// top of the stop-bit field decoder bench: clock, reset, byte stimulus with random
// gaps and output stalls, and the final verdict
// depends on sbfd_pkg, stop_bit_field_decoder and sbfd_checker
module testbench;

    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    localparam int ITEM_TARGET = 1400;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SAT_LEN = 260;

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic        m_tlast;

    int  mismatches;
    int  waiting;
    int  checked;
    int  cycles;
    int  items_sent;
    int  bytes_sent;
    int  long_fields;
    bit  idle_en = 1'b1;

    stop_bit_field_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    sbfd_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .waiting    (waiting),
        .checked    (checked)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= !idle_en || ($urandom_range(99) >= 26);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, waiting);
            $display("status: fail");
            $finish;
        end
    end

    // called right after a rising edge; returns right after the edge that took the transfer
    task automatic send_byte(input logic [7:0] b, input logic [2:0] m);
        bit ok;
        while (idle_en && $urandom_range(99) < 26) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= m;
        do begin
            @(negedge aclk);
            ok = s_tready;
            @(posedge aclk);
        end while (!ok);
        bytes_sent++;
    endtask

    // later bytes of a field carry a random mode, which the block must ignore
    task automatic send_field(input logic [2:0] mode, input int len, input fill_t fill);
        logic [6:0] data;
        logic [2:0] m;
        for (int i = 0; i < len; i++) begin
            case (fill)
                FILL_ZERO: data = '0;
                FILL_ONES: data = '1;
                default:   data = 7'($urandom_range(127));
            endcase
            m = (i == 0) ? mode : 3'($urandom_range(7));
            send_byte({i == len - 1, data}, m);
            if (mode <= sbfd_pkg::MODE_ASCII)
                items_sent++;
        end
    endtask

    initial begin
        logic [2:0] mode;
        int         len;
        int         r;
        fill_t      fill;
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        items_sent = 0;
        bytes_sent = 0;
        long_fields = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, every mode, sign extension, too many bytes, spare modes
        send_field(sbfd_pkg::MODE_UINT32, 1, FILL_ZERO);
        send_field(sbfd_pkg::MODE_UINT32, 1, FILL_ONES);
        send_field(sbfd_pkg::MODE_UINT32, 5, FILL_ONES);
        send_field(sbfd_pkg::MODE_INT32, 1, FILL_ONES);
        send_field(sbfd_pkg::MODE_INT32, 2, FILL_ZERO);
        send_field(sbfd_pkg::MODE_INT64, 10, FILL_ONES);
        send_field(sbfd_pkg::MODE_UINT64, 1, FILL_RANDOM);
        send_field(sbfd_pkg::MODE_PMAP, 2, FILL_RANDOM);
        send_field(sbfd_pkg::MODE_ASCII, 2, FILL_RANDOM);
        send_field(MODE_SPARE_LO, 1, FILL_RANDOM);
        send_field(MODE_SPARE_HI, 1, FILL_RANDOM);

        // one byte count saturation field up front, more later at random
        send_field(3'($urandom_range(5)), SAT_LEN, FILL_RANDOM);
        long_fields++;

        while (bytes_sent < ITEM_TARGET) begin
            // a stretch with no gaps and no stalls at all
            idle_en = !(items_sent >= 600 && items_sent < 900);
            r = $urandom_range(99);
            if (r < 5)
                mode = $urandom_range(1) ? MODE_SPARE_LO : MODE_SPARE_HI;
            else
                mode = 3'($urandom_range(5));
            r = $urandom_range(9);
            fill = (r < 7) ? FILL_RANDOM : (r < 8) ? FILL_ZERO : FILL_ONES;
            if (bytes_sent + SAT_LEN < ITEM_TARGET && $urandom_range(299) == 0) begin
                len = SAT_LEN;
                long_fields++;
            end else if (mode <= sbfd_pkg::MODE_INT64) begin
                if ($urandom_range(99) < 80)
                    len = $urandom_range((mode >= sbfd_pkg::MODE_UINT64) ? 10 : 5, 1);
                else
                    len = $urandom_range(14, 1);
            end else begin
                len = $urandom_range(6, 1);
            end
            send_field(mode, len, fill);
        end
        s_tvalid <= 1'b0;
        idle_en = 1'b1;

        // let the checker take in the last transfer before looking at the queue
        @(negedge aclk);
        while (waiting != 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);

        $display("covered %0d bytes (%0d in decoded modes), %0d results checked,",
                 bytes_sent, items_sent, checked);
        $display("all six modes plus spare codes, sign extension, overflow, %0d saturating fields",
                 long_fields);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("status: fail");
        end
        $finish;
    end

endmodule

### stop_bit_field_decoder.f
rtl/sbfd_pkg.sv
rtl/sbfd_step.sv
rtl/stop_bit_field_decoder.sv
sim/sbfd_checker.sv
sim/testbench.sv
